[sv/abs_pkg.sv]
// ----------------------------------------------------------------------------
// abs_pkg
// Shared constants, operation codes and word types of the averaging
// background subtractor.
// ----------------------------------------------------------------------------
package abs_pkg;

   localparam logic [1:0] OP_LEARN    = 2'd0;
   localparam logic [1:0] OP_BUILD    = 2'd1;
   localparam logic [1:0] OP_CLASSIFY = 2'd2;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   localparam logic CSR_HIGH_SCALE = 1'b0;
   localparam logic CSR_LOW_SCALE  = 1'b1;

   localparam int CHANS   = 3;
   localparam int LANES   = 2 * CHANS;
   localparam int CH_W    = 8;
   localparam int PIX_W   = 16;
   localparam int SUM_W   = 24;
   localparam int N_W     = 16;
   localparam int FRAC_W  = 8;
   localparam int AVG_W   = 21;
   localparam int Q_W     = 22;
   localparam int SCALE_W = 8;
   localparam int PROD_W  = SCALE_W + Q_W;
   localparam int TOP_W   = SUM_W + FRAC_W - AVG_W;
   localparam int RND_SH  = 4;
   localparam int MASK_W  = 8;

   localparam logic [SUM_W-1:0]   SUM_MAX  = '1;
   localparam logic [AVG_W-1:0]   AVG_MAX  = '1;
   localparam logic [N_W-1:0]     N_MAX    = '1;
   localparam logic [MASK_W-1:0]  MASK_FG  = '1;
   localparam logic [SCALE_W-1:0] HIGH_SCALE_RST = 8'd112;
   localparam logic [SCALE_W-1:0] LOW_SCALE_RST  = 8'd96;

   typedef struct packed {
      logic [1:0]       req_type;
      logic             camera;
      logic [PIX_W-1:0] pixel_index;
      logic [CH_W-1:0]  chan_a;
      logic [CH_W-1:0]  chan_b;
      logic [CH_W-1:0]  chan_c;
      logic             frame_end;
   } req_word_type;

   typedef struct packed {
      logic [1:0]        op_done;
      logic [MASK_W-1:0] mask;
   } rsp_word_type;

endpackage

[sv/abs_req_if.sv]
// ----------------------------------------------------------------------------
// abs_req_if
// Pixel request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface abs_req_if;
   import abs_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

[sv/abs_rsp_if.sv]
// ----------------------------------------------------------------------------
// abs_rsp_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface abs_rsp_if;
   import abs_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

[sv/average_background_subtractor_core.sv]
// ----------------------------------------------------------------------------
// average_background_subtractor_core
// Per-pixel averaging background model: learn, build thresholds, classify.
// ----------------------------------------------------------------------------
// One request word is taken per clock while req ready is high, and every word
// gives one result word, in order. The depth of the path from acceptance to the
// result queue is set mostly by the 21-stage bit-per-stage divider that forms
// the mean sum and mean difference. Up to 32 words may be in flight or queued,
// so a stalled result side backs up into req ready only after 32 words. After
// reset a clearing pass over all CAMERAS*PIXELS slots zeroes the sum and bound
// memories; no word is taken during it (csr writes still are).
// ----------------------------------------------------------------------------
module average_background_subtractor_core #(
   parameter int PIXELS  = 65536,
   parameter int CAMERAS = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   abs_req_if.sink                     req_chan,
   abs_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [abs_pkg::SCALE_W-1:0] csr_wdata
);
   import abs_pkg::*;

   localparam int SLOTS      = CAMERAS * PIXELS;
   localparam int ADDR_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CAM_W      = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
   localparam bit PIX_WRAP   = (PIXELS < 65536);
   localparam longint unsigned RECIP = (64'd1 << 31) / PIXELS;
   localparam logic [31:0] RECIP_C   = 32'(RECIP);
   localparam logic [16:0] PIX_C     = 17'(PIXELS);
   localparam logic [ADDR_W-1:0] CAM_BASE = ADDR_W'(PIXELS);
   localparam logic [ADDR_W-1:0] SLOT_LAST = ADDR_W'(SLOTS - 1);
   localparam int DIV_STEPS  = AVG_W;
   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_AW    = 5;
   localparam int OCC_W      = FIFO_AW + 1;
   localparam int WIDE_W     = 28;
   localparam logic signed [WIDE_W-1:0] HI_LIM = 28'sd2097151;
   localparam logic signed [WIDE_W-1:0] LO_LIM = -28'sd2097152;

   typedef logic [CHANS-1:0][CH_W-1:0]  pixel_type;
   typedef logic [LANES-1:0][SUM_W-1:0] accum_type;
   typedef logic [LANES-1:0][Q_W-1:0]   bound_type;

   typedef struct packed {
      logic             vld;
      logic [1:0]       op;
      logic [CAM_W-1:0] cam;
      logic [PIX_W-1:0] pix;
      pixel_type        ch;
      logic             seen;
      logic [N_W-1:0]   n;
   } front_type;

   typedef struct packed {
      logic              vld;
      logic [1:0]        op;
      logic [ADDR_W-1:0] slot;
      pixel_type         ch;
      logic              seen;
      logic [N_W-1:0]    n;
   } mid_type;

   typedef struct packed {
      logic              vld;
      logic [ADDR_W-1:0] slot;
      accum_type         acc;
      pixel_type         prev;
   } wrec_type;

   typedef struct packed {
      logic              vld;
      logic [1:0]        op;
      logic [ADDR_W-1:0] slot;
      pixel_type         ch;
      logic              nzero;
      logic [LANES-1:0]  ovf;
      logic [N_W-1:0]    n;
   } side_type;

   typedef struct packed {
      logic [N_W-1:0]   rem;
      logic [AVG_W-1:0] work;
   } lane_type;

   typedef lane_type [LANES-1:0] lanes_type;

   // control and configuration
   logic [SCALE_W-1:0] high_scale_ff;
   logic [SCALE_W-1:0] low_scale_ff;
   logic               seen_ff   [CAMERAS];
   logic [N_W-1:0]     frames_ff [CAMERAS];
   logic               clr_ff;
   logic [ADDR_W-1:0]  clr_cnt_ff;
   logic [OCC_W-1:0]   occ_ff;
   logic [OCC_W-1:0]   occ_in;
   logic               acc_req;
   logic               pop;
   logic [CAM_W-1:0]   cam_idx;

   // pipeline
   front_type          front1_in, front1_ff, front2_ff, front3_ff;
   logic [47:0]        prod1_ff;
   logic [32:0]        qp_full;
   logic [16:0]        qp_ff;
   logic [16:0]        pix_r;
   logic [16:0]        pix_m;
   mid_type            mid4_in, mid4_ff, mid5_ff;
   accum_type          acc_rd_ff;
   pixel_type          prev_rd_ff;
   wrec_type           wr_in, wr_ff;
   accum_type          cur_acc;
   pixel_type          cur_prev;
   side_type           side_in;
   side_type           side_ff [DIV_STEPS+1];
   lanes_type          lane_in [DIV_STEPS+1];
   lanes_type          lane_ff [DIV_STEPS+1];
   side_type           bnd1_ff, bnd2_ff, cls_ff;
   logic [CHANS-1:0][AVG_W-1:0]  avg_in, avg_ff;
   logic [CHANS-1:0][PROD_W-1:0] up_prod_in, up_prod_ff, dn_prod_in, dn_prod_ff;
   bound_type          bnd_in, bnd_ff, bnd_rd_ff;
   logic               in_band;
   rsp_word_type       push_word;

   // memories
   accum_type          acc_mem  [SLOTS];
   pixel_type          prev_mem [SLOTS];
   bound_type          bnd_mem  [SLOTS];
   logic               acc_we;
   logic [ADDR_W-1:0]  acc_waddr;
   accum_type          acc_wdata;
   logic               bnd_we;
   logic [ADDR_W-1:0]  bnd_waddr;
   bound_type          bnd_wdata;

   // result queue
   rsp_word_type       fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OCC_W-1:0]   cnt_ff;

   // ---------------------------------------------------------------- handshake
   assign req_chan.ready = ~clr_ff && (occ_ff < OCC_W'(FIFO_DEPTH));
   assign acc_req        = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = (cnt_ff != '0);
   assign rsp_chan.data  = fifo_ff[rd_ptr_ff];
   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign occ_in         = occ_ff + OCC_W'(acc_req) - OCC_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_scale_ff <= HIGH_SCALE_RST;
         low_scale_ff  <= LOW_SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HIGH_SCALE: high_scale_ff <= csr_wdata;
            CSR_LOW_SCALE:  low_scale_ff  <= csr_wdata;
            default:        high_scale_ff <= high_scale_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clr_ff) begin
         if (clr_cnt_ff == SLOT_LAST) begin
            clr_ff <= 1'b0;
         end else begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- per camera
   assign cam_idx = (CAMERAS == 1) ? '0 : CAM_W'(req_chan.data.camera);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAMERAS; i++) begin
            seen_ff[i]   <= 1'b0;
            frames_ff[i] <= '0;
         end
      end else if (acc_req && req_chan.data.req_type == OP_LEARN
                   && req_chan.data.frame_end) begin
         if (seen_ff[cam_idx] && frames_ff[cam_idx] != N_MAX) begin
            frames_ff[cam_idx] <= frames_ff[cam_idx] + 1'b1;
         end
         seen_ff[cam_idx] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- front: slot
   always_comb begin
      front1_in.vld   = acc_req;
      front1_in.op    = req_chan.data.req_type;
      front1_in.cam   = cam_idx;
      front1_in.pix   = req_chan.data.pixel_index;
      front1_in.ch    = {req_chan.data.chan_c, req_chan.data.chan_b, req_chan.data.chan_a};
      front1_in.seen  = seen_ff[cam_idx];
      front1_in.n     = frames_ff[cam_idx];
   end

   // pixel index modulo PIXELS by reciprocal multiply and one correction
   assign qp_full = 33'(prod1_ff[46:31]) * 33'(PIX_C);

   always_comb begin
      pix_r = {1'b0, front3_ff.pix} - qp_ff;
      if (pix_r >= PIX_C) begin
         pix_r = pix_r - PIX_C;
      end
      pix_m = PIX_WRAP ? pix_r : {1'b0, front3_ff.pix};
      mid4_in.vld  = front3_ff.vld;
      mid4_in.op   = front3_ff.op;
      mid4_in.slot = ((front3_ff.cam != '0) ? CAM_BASE : '0) + ADDR_W'(pix_m);
      mid4_in.ch   = front3_ff.ch;
      mid4_in.seen = front3_ff.seen;
      mid4_in.n    = front3_ff.n;
   end

   always_ff @(posedge clock) begin
      prod1_ff  <= 48'(front1_ff.pix) * 48'(RECIP_C);
      qp_ff     <= qp_full[16:0];
      if (reset) begin
         front1_ff <= '0;
         front2_ff <= '0;
         front3_ff <= '0;
         mid4_ff   <= '0;
         mid5_ff   <= '0;
      end else begin
         front1_ff <= front1_in;
         front2_ff <= front1_ff;
         front3_ff <= front2_ff;
         mid4_ff   <= mid4_in;
         mid5_ff   <= mid4_ff;
      end
   end

   // ---------------------------------------------------------------- sums
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_waddr] <= acc_wdata;
      end
      acc_rd_ff <= acc_mem[mid4_ff.slot];
   end

   always_ff @(posedge clock) begin
      if (wr_in.vld) begin
         prev_mem[mid5_ff.slot] <= mid5_ff.ch;
      end
      prev_rd_ff <= prev_mem[mid4_ff.slot];
   end

   always_comb begin
      logic [CH_W-1:0]  dif;
      logic [SUM_W:0]   s_sum;
      logic [SUM_W:0]   s_dif;
      logic             fwd;
      fwd      = wr_ff.vld && (wr_ff.slot == mid5_ff.slot);
      cur_acc  = fwd ? wr_ff.acc  : acc_rd_ff;
      cur_prev = fwd ? wr_ff.prev : prev_rd_ff;
      wr_in.vld  = mid5_ff.vld && (mid5_ff.op == OP_LEARN);
      wr_in.slot = mid5_ff.slot;
      wr_in.prev = mid5_ff.ch;
      wr_in.acc  = cur_acc;
      for (int c = 0; c < CHANS; c++) begin
         dif   = (mid5_ff.ch[c] > cur_prev[c]) ? mid5_ff.ch[c] - cur_prev[c]
                                               : cur_prev[c] - mid5_ff.ch[c];
         s_sum = {1'b0, cur_acc[c]} + (SUM_W+1)'(mid5_ff.ch[c]);
         s_dif = {1'b0, cur_acc[CHANS+c]} + (SUM_W+1)'(dif);
         if (mid5_ff.seen) begin
            wr_in.acc[c]       = s_sum[SUM_W] ? SUM_MAX : s_sum[SUM_W-1:0];
            wr_in.acc[CHANS+c] = s_dif[SUM_W] ? SUM_MAX : s_dif[SUM_W-1:0];
         end
      end
      acc_we    = clr_ff || wr_in.vld;
      acc_waddr = clr_ff ? clr_cnt_ff : mid5_ff.slot;
      acc_wdata = clr_ff ? '0 : wr_in.acc;

      side_in.vld   = mid5_ff.vld;
      side_in.op    = mid5_ff.op;
      side_in.slot  = mid5_ff.slot;
      side_in.ch    = mid5_ff.ch;
      side_in.nzero = (mid5_ff.n == '0);
      side_in.n     = mid5_ff.n;
      for (int l = 0; l < LANES; l++) begin
         side_in.ovf[l]      = N_W'(cur_acc[l][SUM_W-1 -: TOP_W]) >= mid5_ff.n;
         lane_in[0][l].rem  = N_W'(cur_acc[l][SUM_W-1 -: TOP_W]);
         lane_in[0][l].work = {cur_acc[l][SUM_W-TOP_W-1:0], FRAC_W'(0)};
      end
   end

   always_ff @(posedge clock) begin
      lane_ff[0] <= lane_in[0];
      if (reset) begin
         wr_ff      <= '0;
         side_ff[0] <= '0;
      end else begin
         wr_ff      <= wr_in;
         side_ff[0] <= side_in;
      end
   end

   // ---------------------------------------------------------------- divider
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      always_comb begin
         logic [N_W:0] rem2;
         logic         ge;
         for (int l = 0; l < LANES; l++) begin
            rem2 = {lane_ff[k-1][l].rem, lane_ff[k-1][l].work[AVG_W-1]};
            ge   = rem2 >= {1'b0, side_ff[k-1].n};
            lane_in[k][l].rem  = ge ? N_W'(rem2 - {1'b0, side_ff[k-1].n}) : N_W'(rem2);
            lane_in[k][l].work = {lane_ff[k-1][l].work[AVG_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         lane_ff[k] <= lane_in[k];
         if (reset) begin
            side_ff[k] <= '0;
         end else begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- bounds
   always_comb begin
      logic [AVG_W-1:0] q [LANES];
      logic [Q_W-1:0]   dif1;
      for (int l = 0; l < LANES; l++) begin
         q[l] = side_ff[DIV_STEPS].nzero  ? '0 :
                side_ff[DIV_STEPS].ovf[l] ? AVG_MAX : lane_ff[DIV_STEPS][l].work;
      end
      for (int c = 0; c < CHANS; c++) begin
         dif1          = Q_W'(q[CHANS+c]) + Q_W'(1 << FRAC_W);
         avg_in[c]     = q[c];
         up_prod_in[c] = PROD_W'(high_scale_ff) * PROD_W'(dif1);
         dn_prod_in[c] = PROD_W'(low_scale_ff) * PROD_W'(dif1);
      end
   end

   always_comb begin
      logic signed [WIDE_W-1:0] up_w;
      logic signed [WIDE_W-1:0] lo_w;
      logic [PROD_W:0]          r_up;
      logic [PROD_W:0]          r_dn;
      for (int c = 0; c < CHANS; c++) begin
         r_up = {1'b0, up_prod_ff[c]} + (PROD_W+1)'(1 << (RND_SH - 1));
         r_dn = {1'b0, dn_prod_ff[c]} + (PROD_W+1)'(1 << (RND_SH - 1));
         up_w = $signed(WIDE_W'(avg_ff[c])) + $signed(WIDE_W'(r_up >> RND_SH));
         lo_w = $signed(WIDE_W'(avg_ff[c])) - $signed(WIDE_W'(r_dn >> RND_SH));
         bnd_in[c]       = (up_w > HI_LIM) ? Q_W'(HI_LIM) : Q_W'(up_w);
         bnd_in[CHANS+c] = (lo_w < LO_LIM) ? Q_W'(LO_LIM) : Q_W'(lo_w);
      end
   end

   always_ff @(posedge clock) begin
      avg_ff     <= avg_in;
      up_prod_ff <= up_prod_in;
      dn_prod_ff <= dn_prod_in;
      bnd_ff     <= bnd_in;
      if (reset) begin
         bnd1_ff <= '0;
         bnd2_ff <= '0;
         cls_ff  <= '0;
      end else begin
         bnd1_ff <= side_ff[DIV_STEPS];
         bnd2_ff <= bnd1_ff;
         cls_ff  <= bnd2_ff;
      end
   end

   // build writes and classify reads at the same stage, so order holds
   assign bnd_we    = clr_ff || (bnd2_ff.vld && bnd2_ff.op == OP_BUILD);
   assign bnd_waddr = clr_ff ? clr_cnt_ff : bnd2_ff.slot;
   assign bnd_wdata = clr_ff ? '0 : bnd_ff;

   always_ff @(posedge clock) begin
      if (bnd_we) begin
         bnd_mem[bnd_waddr] <= bnd_wdata;
      end
      bnd_rd_ff <= bnd_mem[bnd2_ff.slot];
   end

   // ---------------------------------------------------------------- classify
   always_comb begin
      logic signed [Q_W-1:0] v;
      in_band = 1'b0;
      for (int c = 0; c < CHANS; c++) begin
         v = $signed({(Q_W-CH_W-FRAC_W)'(0), cls_ff.ch[c], FRAC_W'(0)});
         if ($signed(bnd_rd_ff[CHANS+c]) <= v && v < $signed(bnd_rd_ff[c])) begin
            in_band = 1'b1;
         end
      end
      push_word.op_done = cls_ff.op;
      push_word.mask    = (cls_ff.op == OP_CLASSIFY && !in_band) ? MASK_FG : '0;
   end

   // ---------------------------------------------------------------- result queue
   always_ff @(posedge clock) begin
      if (cls_ff.vld) begin
         fifo_ff[wr_ptr_ff] <= push_word;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (cls_ff.vld) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + OCC_W'(cls_ff.vld) - OCC_W'(pop);
      end
   end

endmodule

[tb/average_background_subtractor_core_tb.sv]
// ----------------------------------------------------------------------------
// average_background_subtractor_core_tb
// Self-checking bench: drives learn/build/classify pixel words under random
// idling and back-pressure, predicts every result word and compares in order.
// ----------------------------------------------------------------------------
module average_background_subtractor_core_tb;
   import abs_pkg::*;

   localparam int Q_HI = 2097151;
   localparam int Q_LO = -2097152;
   localparam int POOL = 4;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [SCALE_W-1:0] csr_wdata;

   abs_req_if req_bus ();
   abs_rsp_if rsp_bus ();

   average_background_subtractor_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model state, keyed by (camera*65536 + pixel)*3 + channel
   bit [7:0]  last_pix[int];
   bit [23:0] chan_acc[int];
   bit [23:0] diff_acc[int];
   int        up_thr[int];
   int        dn_thr[int];
   bit [15:0] frame_cnt[2];
   bit        primed[2];
   bit [7:0]  hi_scale;
   bit [7:0]  lo_scale;

   rsp_word_type pending_rsp[$];
   int errors;
   int idle_pct;
   int stall_pct;
   logic hold_off;

   bit [15:0] pool_pix[2][POOL];
   bit [7:0]  pool_base[2][POOL];

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic bit [23:0] sat_add(bit [23:0] a, bit [7:0] b);
      bit [24:0] s;
      s = a + b;
      return s[24] ? 24'hFFFFFF : s[23:0];
   endfunction

   function automatic longint mean_q(bit [23:0] s, bit [15:0] n);
      longint q;
      if (n == 0) return 0;
      q = (longint'(s) << 8) / n;
      return q > Q_HI ? Q_HI : q;
   endfunction

   function automatic int clip22(longint v);
      if (v > Q_HI) return Q_HI;
      if (v < Q_LO) return Q_LO;
      return int'(v);
   endfunction

   function automatic rsp_word_type model_pixel(req_word_type w);
      rsp_word_type r;
      bit [7:0] ch[3];
      bit [7:0] p, d;
      int base, k, v;
      longint avg, dif;
      bit in_band;
      ch[0] = w.chan_a; ch[1] = w.chan_b; ch[2] = w.chan_c;
      base = (int'(w.camera) * 65536 + int'(w.pixel_index)) * 3;
      r.op_done = w.req_type;
      r.mask = '0;
      case (w.req_type)
         OP_LEARN: begin
            for (int c = 0; c < 3; c++) begin
               k = base + c;
               if (primed[w.camera]) begin
                  p = last_pix.exists(k) ? last_pix[k] : 8'd0;
                  d = ch[c] > p ? ch[c] - p : p - ch[c];
                  chan_acc[k] = sat_add(chan_acc.exists(k) ? chan_acc[k] : 24'd0, ch[c]);
                  diff_acc[k] = sat_add(diff_acc.exists(k) ? diff_acc[k] : 24'd0, d);
               end
               last_pix[k] = ch[c];
            end
            if (w.frame_end) begin
               if (primed[w.camera] && frame_cnt[w.camera] != 16'hFFFF)
                  frame_cnt[w.camera]++;
               primed[w.camera] = 1'b1;
            end
         end
         OP_BUILD: begin
            for (int c = 0; c < 3; c++) begin
               k = base + c;
               avg = mean_q(chan_acc.exists(k) ? chan_acc[k] : 24'd0, frame_cnt[w.camera]);
               dif = mean_q(diff_acc.exists(k) ? diff_acc[k] : 24'd0,
                            frame_cnt[w.camera]) + 256;
               up_thr[k] = clip22(avg + ((longint'(hi_scale) * dif + 8) >>> 4));
               dn_thr[k] = clip22(avg - ((longint'(lo_scale) * dif + 8) >>> 4));
            end
         end
         OP_CLASSIFY: begin
            in_band = 1'b0;
            for (int c = 0; c < 3; c++) begin
               k = base + c;
               v = int'(ch[c]) * 256;
               if ((dn_thr.exists(k) ? dn_thr[k] : 0) <= v &&
                   v < (up_thr.exists(k) ? up_thr[k] : 0))
                  in_band = 1'b1;
            end
            r.mask = in_band ? 8'd0 : MASK_FG;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report(string what, int got, int exp_val);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $time);
      errors++;
   endtask

   // result side: random stall plus an optional long hold-off
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            report("unexpected word op", rsp_bus.data.op_done, -1);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_bus.data.op_done !== e.op_done)
               report("op_done", rsp_bus.data.op_done, e.op_done);
            if (rsp_bus.data.mask !== e.mask)
               report("mask", rsp_bus.data.mask, e.mask);
         end
      end
   end

   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= w;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_rsp.push_back(model_pixel(w));
   endtask

   task automatic pixel_word(logic [1:0] op, logic cam, logic [15:0] pix,
                             logic [7:0] a, logic [7:0] b, logic [7:0] c, logic fe);
      req_word_type w;
      w.req_type = op; w.camera = cam; w.pixel_index = pix;
      w.chan_a = a; w.chan_b = b; w.chan_c = c; w.frame_end = fe;
      send_word(w);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_scales(bit [7:0] hs, bit [7:0] ls);
      csr_we <= 1'b1; csr_index <= CSR_HIGH_SCALE; csr_wdata <= hs;
      @(posedge clock);
      csr_index <= CSR_LOW_SCALE; csr_wdata <= ls;
      @(posedge clock);
      csr_we <= 1'b0;
      hi_scale = hs;
      lo_scale = ls;
   endtask

   function automatic bit [7:0] near(bit [7:0] b, int spread);
      int v;
      v = int'(b) + $urandom_range(2 * spread) - spread;
      return v < 0 ? 8'd0 : v > 255 ? 8'd255 : v[7:0];
   endfunction

   task automatic learn_frame(bit cam);
      for (int i = 0; i < POOL; i++)
         pixel_word(OP_LEARN, cam, pool_pix[cam][i], near(pool_base[cam][i], 6),
                    near(pool_base[cam][i], 6), near(pool_base[cam][i], 6), i == POOL - 1);
   endtask

   task automatic test_directed();
      pixel_word(OP_CLASSIFY, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      pixel_word(OP_UNUSED, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      pixel_word(OP_BUILD, 1'b1, 16'hFFFF, 8'd0, 8'd0, 8'd0, 1'b1);
      pixel_word(OP_CLASSIFY, 1'b1, 16'hFFFF, 8'd0, 8'd0, 8'd0, 1'b0);
      for (int cam = 0; cam < 2; cam++) begin
         pixel_word(OP_LEARN, 1'(cam), pool_pix[cam][0], 8'd0, 8'd255, 8'd0, 1'b0);
         pixel_word(OP_LEARN, 1'(cam), pool_pix[cam][1], 8'd255, 8'd0, 8'd255, 1'b0);
         pixel_word(OP_LEARN, 1'(cam), pool_pix[cam][2], 8'd17, 8'd200, 8'd90, 1'b0);
         pixel_word(OP_LEARN, 1'(cam), pool_pix[cam][3], 8'd128, 8'd64, 8'd32, 1'b1);
      end
      learn_frame(1'b0);
      pixel_word(OP_BUILD, 1'b0, pool_pix[0][0], 8'd0, 8'd0, 8'd0, 1'b0);
      pixel_word(OP_BUILD, 1'b0, pool_pix[0][1], 8'd0, 8'd0, 8'd0, 1'b1);
      pixel_word(OP_CLASSIFY, 1'b0, pool_pix[0][0], 8'd0, 8'd255, 8'd0, 1'b0);
      pixel_word(OP_CLASSIFY, 1'b0, pool_pix[0][1], 8'd255, 8'd255, 8'd255, 1'b0);
      pixel_word(OP_CLASSIFY, 1'b0, pool_pix[0][1], 8'd100, 8'd100, 8'd100, 1'b0);
      drain();
   endtask

   task automatic test_random(int items, int idle, int stall);
      int sent;
      bit cam;
      int i;
      idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < items) begin
         cam = 1'($urandom_range(1));
         if ($urandom_range(99) < 70) begin
            learn_frame(cam);
            sent += POOL;
            if ($urandom_range(2) == 0) begin
               for (i = 0; i < POOL; i++)
                  pixel_word(OP_BUILD, cam, pool_pix[cam][i], 8'($urandom), 8'($urandom),
                             8'($urandom), 1'($urandom_range(1)));
               sent += POOL;
            end
            for (i = 0; i < POOL; i++) begin
               if ($urandom_range(1))
                  pixel_word(OP_CLASSIFY, cam, pool_pix[cam][i], near(pool_base[cam][i], 20),
                             near(pool_base[cam][i], 20), near(pool_base[cam][i], 20), 1'b0);
               else
                  pixel_word(OP_CLASSIFY, cam, pool_pix[cam][i], 8'($urandom), 8'($urandom),
                             8'($urandom), 1'($urandom_range(1)));
            end
            sent += POOL;
         end else begin
            i = $urandom_range(3);
            if (i == OP_LEARN)
               pixel_word(OP_LEARN, cam, pool_pix[cam][$urandom_range(POOL - 1)],
                          8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
            else
               pixel_word(i[1:0], cam, 16'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 1'($urandom_range(1)));
            sent++;
         end
      end
      drain();
   endtask

   task automatic test_backpressure();
      idle_pct = 0;
      stall_pct = 0;
      @(posedge clock);
      hold_off <= 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      for (int i = 0; i < 12; i++) learn_frame(1'($urandom_range(1)));
      drain();
   endtask

   initial begin
      #20000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      errors = 0;
      idle_pct = 0;
      stall_pct = 0;
      hold_off = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_HIGH_SCALE;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      hi_scale = HIGH_SCALE_RST;
      lo_scale = LOW_SCALE_RST;
      for (int c = 0; c < 2; c++) begin
         for (int i = 0; i < POOL; i++) begin
            pool_pix[c][i] = (i == 0) ? 16'd0 : (i == 1) ? 16'hFFFF : 16'($urandom);
            pool_base[c][i] = 8'($urandom);
         end
         pool_pix[c][3] = pool_pix[c][2] ^ 16'h0001;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(200, 0, 0);
      set_scales(8'd0, 8'd255);
      test_random(150, 58, 0);
      set_scales(8'd255, 8'd0);
      test_random(150, 0, 58);
      set_scales(8'($urandom), 8'($urandom));
      test_random(200, 37, 37);
      test_backpressure();
      set_scales(8'd16, 8'd16);
      test_random(200, 58, 58);
      set_scales(8'd112, 8'd96);
      test_random(100, 0, 0);

      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[filelist.f]
sv/abs_pkg.sv
sv/abs_req_if.sv
sv/abs_rsp_if.sv
sv/average_background_subtractor_core.sv
tb/average_background_subtractor_core_tb.sv
